// ----- rtl/bprp_pkg.sv -----
package bprp_pkg;

	localparam int MAX_LEN = 16;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int IDX_W   = 4;
	localparam int SAMP_W  = 16;
	localparam int VAL_W   = 15;
	localparam int SUM_W   = 19;
	localparam int LEN_W   = 5;
	localparam int TDATA_W = 72;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef struct packed {
		logic             too_long;
		logic [SUM_W-1:0] sum_to_peak;
		logic [IDX_W-1:0] peak_index;
		logic [VAL_W-1:0] peak_value;
		logic [IDX_W-1:0] best_start;
		logic [LEN_W-1:0] best_len;
		logic [SUM_W-1:0] best_sum;
		logic             found;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

// ----- rtl/best_positive_run_with_peak_core.sv -----
// Best positive run finder with peak tracking.
// Input stream (s_*): one signed Q4.12 sample per request in s_tdata, s_tlast
// on the final sample of a frame. Output stream (m_*): one result per frame,
// issued for the request that carried s_tlast; no result for other requests.
// The last sample is registered in the input stage; the frame result is
// registered in the output stage once that stage can take it, which
// raises m_tvalid.
// Throughput: one sample per cycle unless a last sample waits on a pending
// result; the per-sample update is a single saturating add and a handful
// of compares between the input register and the tracking registers.
// Only samples of the first MAX_LEN of a frame enter the search; later ones
// set too_long and are otherwise dropped until s_tlast.
// Reset (arst_n low) empties both stages and clears the frame state; the
// block restarts with an empty frame. After each frame the state clears.
// When the receiver stalls with a result pending, non-last samples keep
// flowing; a further last sample waits in the input stage and s_tready drops
// until the pending result is taken.
module best_positive_run_with_peak_core import bprp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [SAMP_W-1:0]  s_tdata,   // [15:0] sample (signed)
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	// [0] found, [19:1] best_sum, [24:20] best_len, [28:25] best_start,
	// [43:29] peak_value, [47:44] peak_index, [66:48] sum_to_peak,
	// [67] too_long, [71:68] zero
	output logic [TDATA_W-1:0] m_tdata
);

	logic              valid_s1;
	logic [SAMP_W-1:0] sample_s1;
	logic              last_s1;
	logic              advance;
	logic              load_out;
	result_t           result;
	result_t           result_q;
	logic              out_valid_q;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign load_out = advance && last_s1;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata;
			last_s1   <= s_tlast;
		end
	end

	bprp_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.sample (sample_s1),
		.last   (last_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W-RESULT_W){1'b0}}, result_q};

	a_rise_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result appeared without a last sample");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(sample_s1) && $stable(last_s1)))
		else $error("stalled input stage lost its sample");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.found == (result_q.best_len != '0)))
		else $error("found disagrees with best_len");

	a_peak_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.found) |->
		(result_q.peak_index >= result_q.best_start &&
		 result_q.sum_to_peak <= result_q.best_sum))
		else $error("peak lies outside the best run");

endmodule

// ----- rtl/bprp_track.sv -----
module bprp_track import bprp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [SAMP_W-1:0] sample,
	input  logic              last,
	output result_t           result
);

	logic [CNT_W-1:0] item_count_q;
	logic [SUM_W-1:0] run_sum_q, run_sum_n;
	logic [LEN_W-1:0] run_len_q, run_len_n;
	logic [IDX_W-1:0] run_start_q, run_start_n;
	logic [VAL_W-1:0] run_peak_val_q, run_peak_val_n;
	logic [IDX_W-1:0] run_peak_idx_q, run_peak_idx_n;
	logic [SUM_W-1:0] run_sum_at_peak_q, run_sum_at_peak_n;
	logic [SUM_W-1:0] best_sum_q, best_sum_n;
	logic [LEN_W-1:0] best_len_q, best_len_n;
	logic [IDX_W-1:0] best_start_q, best_start_n;
	logic [VAL_W-1:0] best_peak_val_q, best_peak_val_n;
	logic [IDX_W-1:0] best_peak_idx_q, best_peak_idx_n;
	logic [SUM_W-1:0] best_sum_at_peak_q, best_sum_at_peak_n;
	logic             overflow_q, overflow_n;

	logic             in_range;
	logic             positive;
	logic [VAL_W-1:0] v;
	logic [IDX_W-1:0] idx;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_sat;
	logic             found;

	assign in_range = item_count_q < CNT_W'(MAX_LEN);
	assign v        = sample[VAL_W-1:0];
	assign positive = !sample[SAMP_W-1] && (v != '0);
	assign idx      = item_count_q[IDX_W-1:0];
	assign sum_wide = {1'b0, run_sum_q} + {{(SUM_W+1-VAL_W){1'b0}}, v};
	assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

	always_comb begin
		run_sum_n          = run_sum_q;
		run_len_n          = run_len_q;
		run_start_n        = run_start_q;
		run_peak_val_n     = run_peak_val_q;
		run_peak_idx_n     = run_peak_idx_q;
		run_sum_at_peak_n  = run_sum_at_peak_q;
		best_sum_n         = best_sum_q;
		best_len_n         = best_len_q;
		best_start_n       = best_start_q;
		best_peak_val_n    = best_peak_val_q;
		best_peak_idx_n    = best_peak_idx_q;
		best_sum_at_peak_n = best_sum_at_peak_q;
		overflow_n         = overflow_q;
		if (!in_range) begin
			overflow_n = 1'b1;
		end else if (!positive) begin
			run_sum_n         = '0;
			run_len_n         = '0;
			run_start_n       = '0;
			run_peak_val_n    = '0;
			run_peak_idx_n    = '0;
			run_sum_at_peak_n = '0;
		end else begin
			if (run_len_q == '0) begin
				run_start_n       = idx;
				run_sum_n         = {{(SUM_W-VAL_W){1'b0}}, v};
				run_len_n         = LEN_W'(1);
				run_peak_val_n    = v;
				run_peak_idx_n    = idx;
				run_sum_at_peak_n = {{(SUM_W-VAL_W){1'b0}}, v};
			end else begin
				run_sum_n = sum_sat;
				run_len_n = run_len_q + LEN_W'(1);
				if (v > run_peak_val_q) begin
					run_peak_val_n    = v;
					run_peak_idx_n    = idx;
					run_sum_at_peak_n = sum_sat;
				end
			end
			// ties in sum go to the longer run
			if (run_sum_n > best_sum_q ||
			    (run_sum_n == best_sum_q && run_len_n > best_len_q)) begin
				best_sum_n         = run_sum_n;
				best_len_n         = run_len_n;
				best_start_n       = run_start_n;
				best_peak_val_n    = run_peak_val_n;
				best_peak_idx_n    = run_peak_idx_n;
				best_sum_at_peak_n = run_sum_at_peak_n;
			end
		end
	end

	assign found              = best_len_n != '0;
	assign result.found       = found;
	assign result.best_sum    = found ? best_sum_n : '0;
	assign result.best_len    = found ? best_len_n : '0;
	assign result.best_start  = found ? best_start_n : '0;
	assign result.peak_value  = found ? best_peak_val_n : '0;
	assign result.peak_index  = found ? best_peak_idx_n : '0;
	assign result.sum_to_peak = found ? best_sum_at_peak_n : '0;
	assign result.too_long    = overflow_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q       <= '0;
			run_sum_q          <= '0;
			run_len_q          <= '0;
			run_start_q        <= '0;
			run_peak_val_q     <= '0;
			run_peak_idx_q     <= '0;
			run_sum_at_peak_q  <= '0;
			best_sum_q         <= '0;
			best_len_q         <= '0;
			best_start_q       <= '0;
			best_peak_val_q    <= '0;
			best_peak_idx_q    <= '0;
			best_sum_at_peak_q <= '0;
			overflow_q         <= 1'b0;
		end else if (step) begin
			if (last) begin
				// frame done: back to the reset picture
				item_count_q       <= '0;
				run_sum_q          <= '0;
				run_len_q          <= '0;
				run_start_q        <= '0;
				run_peak_val_q     <= '0;
				run_peak_idx_q     <= '0;
				run_sum_at_peak_q  <= '0;
				best_sum_q         <= '0;
				best_len_q         <= '0;
				best_start_q       <= '0;
				best_peak_val_q    <= '0;
				best_peak_idx_q    <= '0;
				best_sum_at_peak_q <= '0;
				overflow_q         <= 1'b0;
			end else begin
				if (in_range) begin
					item_count_q <= item_count_q + CNT_W'(1);
				end
				run_sum_q          <= run_sum_n;
				run_len_q          <= run_len_n;
				run_start_q        <= run_start_n;
				run_peak_val_q     <= run_peak_val_n;
				run_peak_idx_q     <= run_peak_idx_n;
				run_sum_at_peak_q  <= run_sum_at_peak_n;
				best_sum_q         <= best_sum_n;
				best_len_q         <= best_len_n;
				best_start_q       <= best_start_n;
				best_peak_val_q    <= best_peak_val_n;
				best_peak_idx_q    <= best_peak_idx_n;
				best_sum_at_peak_q <= best_sum_at_peak_n;
				overflow_q         <= overflow_n;
			end
		end
	end

endmodule
